FILE: hw/rtl/lir_pkg.sv
//------------------------------------------------------------------------------
// Linear interpolation resampler package
// Shared types, register indexes and constants of the resampler block.
//------------------------------------------------------------------------------
`default_nettype none

package lir_pkg;

  localparam int SAMPLE_WIDTH_DEF    = 24;
  localparam int CHANNELS_DEF        = 2;
  localparam int PHASE_FRAC_BITS_DEF = 20;

  localparam int STEP_W      = 24;
  localparam int CHAN_W      = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [STEP_W-1:0] STEP_RESET = 24'h100000;
  localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;
  localparam logic [CHAN_W-1:0] CHAN_STEREO = 2'd2;

  localparam int MAX_RES = 64;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_RATIO    = 2'd0,
    REG_CHANNEL_COUNT = 2'd1
  } lir_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_L,
    ST_SUM_L,
    ST_MUL_R,
    ST_SUM_R,
    ST_EMIT
  } lir_state_t;

  typedef struct packed {
    logic mul;
    logic sum;
  } lir_mix_op_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              stereo;
  } lir_cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lir_mix.sv
//------------------------------------------------------------------------------
// Shared interpolation unit
// Computes a*(1-f) + b*f as a*1 + (b-a)*f in two steps: a registered multiply
// and a registered sum with truncation toward zero.
//------------------------------------------------------------------------------
`default_nettype none

module lir_mix #(
  parameter int SAMPLE_WIDTH    = lir_pkg::SAMPLE_WIDTH_DEF,
  parameter int PHASE_FRAC_BITS = lir_pkg::PHASE_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire lir_pkg::lir_mix_op_t              op,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    a,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    b,
  input  wire logic        [PHASE_FRAC_BITS-1:0] f,
  output logic signed      [SAMPLE_WIDTH-1:0]    res
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int PFB    = PHASE_FRAC_BITS;
  localparam int PROD_W = SW + PFB + 2;

  logic signed [SW:0]        diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SW-1:0]      a_hold;
  logic signed [PROD_W-1:0]  base;
  logic signed [PROD_W-1:0]  total;
  logic signed [PROD_W-1:0]  bias;
  logic signed [PROD_W-1:0]  rounded;

  assign diff = $signed({b[SW-1], b}) - $signed({a[SW-1], a});

  always_ff @(posedge clk) begin
    if (op.mul) begin
      prod   <= diff * $signed({1'b0, f});
      a_hold <= a;
    end
  end

  assign base    = $signed({{2{a_hold[SW-1]}}, a_hold, {PFB{1'b0}}});
  assign total   = base + prod;
  assign bias    = $signed({{(SW + 2){1'b0}}, {PFB{total[PROD_W-1]}}});
  assign rounded = total + bias;

  always_ff @(posedge clk) begin
    if (op.sum) begin
      res <= rounded[PFB+SW-1:PFB];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lir_seq.sv
//------------------------------------------------------------------------------
// Resampler sequencer
// Holds the frame state and phase, steps the shared interpolation unit once
// per channel for each output, and keeps one result back so that the last
// result of a frame can be marked.
//------------------------------------------------------------------------------
`default_nettype none

module lir_seq #(
  parameter int SAMPLE_WIDTH    = lir_pkg::SAMPLE_WIDTH_DEF,
  parameter int PHASE_FRAC_BITS = lir_pkg::PHASE_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire lir_pkg::lir_cfg_t              cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_left,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_right,
  input  wire logic                           last_frame,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      out_left,
  output logic signed [SAMPLE_WIDTH-1:0]      out_right,
  output logic                                run_end
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int PFB     = PHASE_FRAC_BITS;
  localparam int STEP_W  = lir_pkg::STEP_W;
  localparam int CNT_W   = lir_pkg::CNT_W;
  localparam int PHASE_W = ((PFB + 1 > STEP_W) ? PFB + 1 : STEP_W) + 1;
  localparam logic [PHASE_W-1:0] ONE      = PHASE_W'(1) << PFB;
  localparam logic [STEP_W-1:0]  STEP_MIN = STEP_W'(1) << (PFB - 5);
  localparam logic [CNT_W-1:0]   CNT_MAX  = CNT_W'(lir_pkg::MAX_RES);

  lir_pkg::lir_state_t state, state_next;
  logic [PHASE_W-1:0]  phase, phase_next;
  logic [CNT_W-1:0]    count, count_next;
  logic                have_prev, have_prev_next;
  logic                tail_mode, tail_mode_next;
  logic                frame_last, frame_last_next;
  logic                pend_valid, pend_valid_next;
  logic signed [SW-1:0] prev_l, prev_l_next, prev_r, prev_r_next;
  logic signed [SW-1:0] cur_l, cur_l_next, cur_r, cur_r_next;
  logic signed [SW-1:0] pend_l, pend_l_next, pend_r, pend_r_next;
  logic signed [SW-1:0] new_l, new_l_next;

  logic                 push;
  logic                 push_end;
  logic                 out_free;
  logic                 go;
  logic                 in_loop;
  logic [STEP_W-1:0]    eff_step;
  logic [PHASE_W-1:0]   phase_adv;
  logic [PHASE_W-1:0]   phase_wrap;
  logic                 use_right;
  lir_pkg::lir_mix_op_t op;
  logic signed [SW-1:0] mix_a;
  logic signed [SW-1:0] mix_b;
  logic signed [SW-1:0] mix_res;
  logic signed [SW-1:0] emit_l;
  logic signed [SW-1:0] emit_r;

  assign eff_step   = (cfg.step < STEP_MIN) ? STEP_MIN : cfg.step;
  assign phase_adv  = phase + {{(PHASE_W - STEP_W){1'b0}}, eff_step};
  assign phase_wrap = (phase >= ONE) ? phase - ONE : phase;
  assign in_loop    = (phase < ONE) && (count < CNT_MAX);
  assign out_free   = !out_valid || out_ready;
  assign go         = !pend_valid || out_free;

  assign use_right = (state == lir_pkg::ST_MUL_R);
  always_comb begin
    if (use_right) begin
      mix_a = tail_mode ? cur_r : prev_r;
      mix_b = tail_mode ? '0 : cur_r;
    end else begin
      mix_a = tail_mode ? cur_l : prev_l;
      mix_b = tail_mode ? '0 : cur_l;
    end
  end

  lir_mix #(
    .SAMPLE_WIDTH    (SW),
    .PHASE_FRAC_BITS (PFB)
  ) u_mix (
    .clk (clk),
    .op  (op),
    .a   (mix_a),
    .b   (mix_b),
    .f   (phase[PFB-1:0]),
    .res (mix_res)
  );

  assign emit_l = cfg.stereo ? new_l : mix_res;
  assign emit_r = cfg.stereo ? mix_res : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lir_pkg::ST_IDLE;
      phase      <= '0;
      count      <= '0;
      have_prev  <= 1'b0;
      tail_mode  <= 1'b0;
      frame_last <= 1'b0;
      pend_valid <= 1'b0;
      prev_l     <= '0;
      prev_r     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      count      <= count_next;
      have_prev  <= have_prev_next;
      tail_mode  <= tail_mode_next;
      frame_last <= frame_last_next;
      pend_valid <= pend_valid_next;
      prev_l     <= prev_l_next;
      prev_r     <= prev_r_next;
      out_valid  <= push || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    cur_l  <= cur_l_next;
    cur_r  <= cur_r_next;
    pend_l <= pend_l_next;
    pend_r <= pend_r_next;
    new_l  <= new_l_next;
    if (push) begin
      out_left  <= pend_l;
      out_right <= pend_r;
      run_end   <= push_end;
    end
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    count_next      = count;
    have_prev_next  = have_prev;
    tail_mode_next  = tail_mode;
    frame_last_next = frame_last;
    pend_valid_next = pend_valid;
    prev_l_next     = prev_l;
    prev_r_next     = prev_r;
    cur_l_next      = cur_l;
    cur_r_next      = cur_r;
    pend_l_next     = pend_l;
    pend_r_next     = pend_r;
    new_l_next      = new_l;
    push            = 1'b0;
    push_end        = 1'b0;
    in_ready        = 1'b0;
    op              = '0;

    case (state)
      lir_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cur_l_next      = sample_left;
          cur_r_next      = cfg.stereo ? sample_right : '0;
          frame_last_next = last_frame;
          count_next      = '0;
          if (have_prev) begin
            tail_mode_next = 1'b0;
            state_next     = lir_pkg::ST_CHECK;
          end else begin
            prev_l_next    = sample_left;
            prev_r_next    = cfg.stereo ? sample_right : '0;
            have_prev_next = 1'b1;
            if (last_frame) begin
              tail_mode_next = 1'b1;
              state_next     = lir_pkg::ST_CHECK;
            end
          end
        end
      end

      lir_pkg::ST_CHECK: begin
        if (in_loop) begin
          state_next = lir_pkg::ST_MUL_L;
        end else if (!tail_mode) begin
          if (frame_last) begin
            phase_next     = phase_wrap;
            prev_l_next    = cur_l;
            prev_r_next    = cur_r;
            have_prev_next = 1'b1;
            tail_mode_next = 1'b1;
          end else if (go) begin
            phase_next      = phase_wrap;
            prev_l_next     = cur_l;
            prev_r_next     = cur_r;
            have_prev_next  = 1'b1;
            push            = pend_valid;
            push_end        = 1'b1;
            pend_valid_next = 1'b0;
            state_next      = lir_pkg::ST_IDLE;
          end
        end else if (go) begin
          phase_next      = '0;
          prev_l_next     = '0;
          prev_r_next     = '0;
          have_prev_next  = 1'b0;
          push            = pend_valid;
          push_end        = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = lir_pkg::ST_IDLE;
        end
      end

      lir_pkg::ST_MUL_L: begin
        op.mul     = 1'b1;
        state_next = lir_pkg::ST_SUM_L;
      end

      lir_pkg::ST_SUM_L: begin
        op.sum     = 1'b1;
        state_next = cfg.stereo ? lir_pkg::ST_MUL_R : lir_pkg::ST_EMIT;
      end

      lir_pkg::ST_MUL_R: begin
        op.mul     = 1'b1;
        new_l_next = mix_res;
        state_next = lir_pkg::ST_SUM_R;
      end

      lir_pkg::ST_SUM_R: begin
        op.sum     = 1'b1;
        state_next = lir_pkg::ST_EMIT;
      end

      lir_pkg::ST_EMIT: begin
        if (go) begin
          push            = pend_valid;
          push_end        = 1'b0;
          pend_l_next     = emit_l;
          pend_r_next     = emit_r;
          pend_valid_next = 1'b1;
          phase_next      = phase_adv;
          count_next      = count + CNT_W'(1);
          state_next      = lir_pkg::ST_CHECK;
        end
      end

      default: begin
        state_next = lir_pkg::ST_IDLE;
      end
    endcase
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == lir_pkg::ST_IDLE) |-> !pend_valid)
    else $error("pending result left over in idle");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("output count beyond cap");

  a_mul_phase: assert property (@(posedge clk) disable iff (rst)
    (state == lir_pkg::ST_MUL_L) |-> (phase < ONE))
    else $error("interpolation started with phase at or above one");

  a_fresh_phase: assert property (@(posedge clk) disable iff (rst)
    ((state == lir_pkg::ST_IDLE) && !have_prev) |-> (phase == '0))
    else $error("phase not cleared without a stored frame");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !push)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

FILE: hw/rtl/linear_interp_resampler_top.sv
//------------------------------------------------------------------------------
// Linear interpolation resampler
// Converts one- or two-channel PCM frames to a new rate by linear
// interpolation between consecutive frames under a configured phase step.
//------------------------------------------------------------------------------
// One input item is taken, then the block is busy until all results it causes
// have been computed. Each result costs one multiply and one sum step per
// channel on a single shared multiplier, plus an emit state to queue the
// result and a check state to test the phase. An item yields n results (n at
// most 64), and it takes longer for as long as the result register is stalled.
// The last result of an item is held back one step so that run_end can be set
// on it, and it leaves as the block turns ready again.
`default_nettype none

module linear_interp_resampler_top #(
  parameter int SAMPLE_WIDTH    = lir_pkg::SAMPLE_WIDTH_DEF,
  parameter int CHANNELS        = lir_pkg::CHANNELS_DEF,
  parameter int PHASE_FRAC_BITS = lir_pkg::PHASE_FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lir_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [lir_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     sample_left,
  input  wire logic signed [SAMPLE_WIDTH-1:0]     sample_right,
  input  wire logic                               last_frame,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]          out_left,
  output logic signed [SAMPLE_WIDTH-1:0]          out_right,
  output logic                                    run_end
);

  logic [lir_pkg::STEP_W-1:0] step_ratio;
  logic [lir_pkg::CHAN_W-1:0] channel_count;
  lir_pkg::lir_cfg_t          cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio    <= lir_pkg::STEP_RESET;
      channel_count <= lir_pkg::CHAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lir_pkg::REG_STEP_RATIO: begin
          step_ratio <= cfg_data[lir_pkg::STEP_W-1:0];
        end
        lir_pkg::REG_CHANNEL_COUNT: begin
          channel_count <= cfg_data[lir_pkg::CHAN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = '{step: step_ratio,
                 stereo: (CHANNELS == 2) && (channel_count == lir_pkg::CHAN_STEREO)};

  lir_seq #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .last_frame   (last_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_left     (out_left),
    .out_right    (out_right),
    .run_end      (run_end)
  );

endmodule

`default_nettype wire

FILE: tb/tb_linear_interp_resampler_top.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Linear interpolation resampler testbench
// Drives stereo and mono PCM frames through the resampler under a range of
// phase steps, predicts every interpolated output item in a local model of
// the phase arithmetic, and checks the outputs in order with random idling
// on both channels and one long output stall.
//------------------------------------------------------------------------------
module tb_linear_interp_resampler_top;

  localparam int SW = lir_pkg::SAMPLE_WIDTH_DEF;
  localparam int FB = lir_pkg::PHASE_FRAC_BITS_DEF;
  localparam int STEP_W = lir_pkg::STEP_W;
  localparam int CHAN_W = lir_pkg::CHAN_W;
  localparam int CFG_DATA_W = lir_pkg::CFG_DATA_W;
  localparam longint UNIT_PHASE = longint'(1) << FB;
  localparam longint MIN_STEP = UNIT_PHASE >>> 5;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 run_end;
  } resampled_t;

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [lir_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]               cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic signed [SW-1:0]                sample_left = '0;
  logic signed [SW-1:0]                sample_right = '0;
  logic                                last_frame = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [SW-1:0]                out_left;
  logic signed [SW-1:0]                out_right;
  logic                                run_end;

  logic [STEP_W-1:0] step_cfg = lir_pkg::STEP_RESET;
  logic [CHAN_W-1:0] chan_cfg = lir_pkg::CHAN_RESET;
  longint            prev_l = 0;
  longint            prev_r = 0;
  longint            phase = 0;
  bit                have_prev = 1'b0;

  resampled_t resampled_q[$];
  int         errors = 0;
  bit         idle_on = 1'b1;
  int         hold_cycles = 0;

  linear_interp_resampler_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .last_frame   (last_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_left     (out_left),
    .out_right    (out_right),
    .run_end      (run_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [SW-1:0] blend(longint a, longint b, longint f);
    longint s;
    longint q;
    s = a * (UNIT_PHASE - f) + b * f;
    if (s < 0) begin
      q = -((-s) >>> FB);
    end else begin
      q = s >>> FB;
    end
    return q[SW-1:0];
  endfunction

  task automatic interpolate_frame(input logic signed [SW-1:0] l_in,
                                   input logic signed [SW-1:0] r_in, input logic last);
    bit         stereo;
    longint     cl;
    longint     cr;
    longint     step_eff;
    int         n;
    resampled_t r;
    stereo = (chan_cfg == lir_pkg::CHAN_STEREO);
    cl = l_in;
    if (stereo) begin
      cr = r_in;
    end else begin
      cr = 0;
    end
    step_eff = step_cfg;
    if (step_eff < MIN_STEP) begin
      step_eff = MIN_STEP;
    end
    n = 0;
    if (have_prev) begin
      while (phase < UNIT_PHASE && n < lir_pkg::MAX_RES) begin
        r.left = blend(prev_l, cl, phase);
        r.right = stereo ? blend(prev_r, cr, phase) : '0;
        r.run_end = 1'b0;
        resampled_q.push_back(r);
        n++;
        phase += step_eff;
      end
      if (phase >= UNIT_PHASE) begin
        phase -= UNIT_PHASE;
      end
    end
    prev_l = cl;
    prev_r = cr;
    have_prev = 1'b1;
    if (last) begin
      while (phase < UNIT_PHASE && n < lir_pkg::MAX_RES) begin
        r.left = blend(cl, 0, phase);
        r.right = stereo ? blend(cr, 0, phase) : '0;
        r.run_end = 1'b0;
        resampled_q.push_back(r);
        n++;
        phase += step_eff;
      end
      prev_l = 0;
      prev_r = 0;
      phase = 0;
      have_prev = 1'b0;
    end
    if (n > 0) begin
      resampled_q[resampled_q.size()-1].run_end = 1'b1;
    end
  endtask

  always @(posedge clk) begin : output_checker
    resampled_t exp_r;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (resampled_q.size() == 0) begin
          $error("Output item arrived with no expected item pending.");
          errors++;
        end else begin
          exp_r = resampled_q.pop_front();
          if (out_left !== exp_r.left) begin
            $error("out_left: expected %0d, actual %0d", exp_r.left, out_left);
            errors++;
          end
          if (out_right !== exp_r.right) begin
            $error("out_right: expected %0d, actual %0d", exp_r.right, out_right);
            errors++;
          end
          if (run_end !== exp_r.run_end) begin
            $error("run_end: expected %0d, actual %0d", exp_r.run_end, run_end);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lir_pkg::REG_STEP_RATIO) begin
          step_cfg = cfg_data[STEP_W-1:0];
        end else if (cfg_index == lir_pkg::REG_CHANNEL_COUNT) begin
          chan_cfg = cfg_data[CHAN_W-1:0];
        end
      end
      if (in_valid && in_ready) begin
        interpolate_frame(sample_left, sample_right, last_frame);
      end
    end
  end

  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 15) : 0;
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic send_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                            input logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_left <= l;
    sample_right <= r;
    last_frame <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (resampled_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [STEP_W-1:0] step, input logic [CHAN_W-1:0] chans);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= lir_pkg::REG_STEP_RATIO;
    cfg_data <= CFG_DATA_W'(step);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= lir_pkg::REG_CHANNEL_COUNT;
    cfg_data <= CFG_DATA_W'(chans);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_fractional_extremes();
    set_config(24'h0C0000, lir_pkg::CHAN_STEREO);
    send_frame('0, '0, 1'b0);
    send_frame(S_MAX, S_MIN, 1'b0);
    send_frame(S_MIN, S_MAX, 1'b0);
    send_frame(S_MAX, S_MAX, 1'b0);
    send_frame(-SW'(1), SW'(1), 1'b1);
  endtask

  task automatic test_first_frame_is_last();
    set_config(24'h055555, lir_pkg::CHAN_STEREO);
    send_frame(S_MAX, S_MIN, 1'b1);
    send_frame(S_MIN, S_MAX, 1'b1);
  endtask

  task automatic test_small_step();
    set_config('0, lir_pkg::CHAN_STEREO);
    send_frame(S_MAX, S_MIN, 1'b0);
    send_frame(S_MIN, S_MAX, 1'b1);
    set_config(STEP_W'(MIN_STEP - 1), lir_pkg::CHAN_STEREO);
    send_frame(S_MIN, S_MIN, 1'b0);
    send_frame(S_MAX, S_MAX, 1'b1);
  endtask

  task automatic test_large_step();
    set_config({STEP_W{1'b1}}, lir_pkg::CHAN_STEREO);
    send_frame(rand_sample(), rand_sample(), 1'b0);
    send_frame(rand_sample(), rand_sample(), 1'b0);
    send_frame(rand_sample(), rand_sample(), 1'b0);
    send_frame(rand_sample(), rand_sample(), 1'b1);
  endtask

  task automatic test_mono();
    set_config(24'h0A0000, 2'd1);
    send_frame(S_MAX, S_MIN, 1'b0);
    send_frame(S_MIN, S_MAX, 1'b0);
    send_frame(rand_sample(), rand_sample(), 1'b0);
    set_config(24'h0A0000, 2'd0);
    send_frame(rand_sample(), rand_sample(), 1'b0);
    send_frame(rand_sample(), rand_sample(), 1'b0);
    set_config(24'h0A0000, 2'd3);
    send_frame(rand_sample(), rand_sample(), 1'b0);
    send_frame(rand_sample(), rand_sample(), 1'b1);
  endtask

  task automatic test_output_stall();
    set_config(24'h040000, lir_pkg::CHAN_STEREO);
    idle_on = 1'b0;
    hold_cycles = HOLD_OFF_CYCLES;
    for (int k = 0; k < 12; k++) begin
      send_frame(rand_sample(), rand_sample(), k == 11);
    end
    settle();
    idle_on = 1'b1;
  endtask

  task automatic test_random();
    logic [STEP_W-1:0] step;
    logic [CHAN_W-1:0] chans;
    for (int p = 0; p < 7; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: step = STEP_W'($urandom_range(0, 24'h020000));
        3, 4, 5, 6, 7: step = STEP_W'($urandom_range(24'h040000, 24'h180000));
        8: step = STEP_W'($urandom_range(24'h200000, 24'hFFFFFF));
        default: step = $urandom_range(0, 1) ? {STEP_W{1'b1}} : '0;
      endcase
      chans = $urandom_range(0, 1) ? lir_pkg::CHAN_STEREO : CHAN_W'($urandom_range(0, 3));
      set_config(step, chans);
      idle_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 13; k++) begin
        send_frame(rand_sample(), rand_sample(), ($urandom_range(0, 5) == 0) || (k == 12));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_fractional_extremes();
    test_first_frame_is_last();
    test_small_step();
    test_large_step();
    test_mono();
    test_output_stall();
    test_random();
    settle();
    if (errors == 0 && resampled_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
